>>> hdl/zws_pkg.sv
// zws_pkg: shared types and codes of the zoned window stack
// command and status codes, list entry type and cell control type
// no dependencies
package zws_pkg;

	localparam int ID_W  = 16;
	localparam int OUT_W = 5;

	// command codes
	localparam logic [1:0] OP_FIND   = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_RAISE  = 2'd2;
	localparam logic [1:0] OP_LOWER  = 2'd3;

	// result status codes
	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_PRESENT = 2'd1;
	localparam logic [1:0] ST_ABSENT  = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	// how a cell marks the insertion point in the compacted list
	localparam logic [1:0] STOP_ZONE = 2'd0; // first back-zone or empty slot
	localparam logic [1:0] STOP_NONE = 2'd1; // no insertion
	localparam logic [1:0] STOP_ALL  = 2'd2; // insert at the front
	localparam logic [1:0] STOP_END  = 2'd3; // insert after the last entry

	typedef struct packed {
		logic [ID_W-1:0] id;
		logic            zone;
		logic            valid;
	} entry_t;

	typedef struct packed {
		logic       cmp_en;    // beat accepted: capture compare result
		logic       load;      // commit the shifted list
		logic [1:0] stop_mode;
	} cell_ctl_t;

endpackage

>>> hdl/zws_prefix_or.sv
// zws_prefix_or: log-depth prefix OR over a row of cell flags
// bit i of the result is the OR of bits 0 to i of the input
// no dependencies
module zws_prefix_or #(
	parameter int N = 16
) (
	input  logic [N-1:0] flags,
	output logic [N-1:0] prefix
);

	localparam int LV = (N > 1) ? $clog2(N) : 1;

	logic [N-1:0] lvl [LV+1];

	// doubling span at each level
	always_comb begin
		lvl[0] = flags;
		for (int s = 0; s < LV; s++) begin
			for (int i = 0; i < N; i++) begin
				if (i < (1 << s))
					lvl[s+1][i] = lvl[s][i];
				else
					lvl[s+1][i] = lvl[s][i] | lvl[s][i - (1 << s)];
			end
		end
	end

	assign prefix = lvl[LV];

endmodule

>>> hdl/zws_cell.sv
// zws_cell: one slot of the stacking list
// holds an entry, compares it, and shifts toward its neighbors; uses zws_pkg
// driven by zoned_window_stack
module zws_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  zws_pkg::cell_ctl_t          ctl,
	input  logic [zws_pkg::ID_W-1:0]    cmp_id,
	input  logic                        ge_in,
	input  zws_pkg::entry_t             new_ent,
	input  zws_pkg::entry_t             right_ent,
	input  zws_pkg::entry_t             left_prime,
	input  logic                        lt_prev,
	input  logic                        lt_self,
	output zws_pkg::entry_t             ent,
	output zws_pkg::entry_t             prime,
	output logic                        hit,
	output logic                        stop
);

	logic            valid_q;
	logic [zws_pkg::ID_W-1:0] id_q;
	logic            zone_q;
	logic            ge_q;
	zws_pkg::entry_t nxt;

	assign ent.id    = id_q;
	assign ent.zone  = zone_q;
	assign ent.valid = valid_q;

	// match against the incoming command
	assign hit = valid_q && (id_q == cmp_id);

	// view of this slot once the matched entry is taken out
	assign prime = ge_q ? right_ent : ent;

	// insertion point marker
	always_comb begin
		unique case (ctl.stop_mode)
			zws_pkg::STOP_ZONE: stop = !prime.valid || !prime.zone;
			zws_pkg::STOP_NONE: stop = 1'b0;
			zws_pkg::STOP_ALL:  stop = 1'b1;
			zws_pkg::STOP_END:  stop = !prime.valid;
			default:            stop = 1'b0;
		endcase
	end

	// before, at, or after the insertion point
	always_comb begin
		priority if (lt_self)
			nxt = prime;
		else if (lt_prev)
			nxt = new_ent;
		else
			nxt = left_prime;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			ge_q    <= 1'b0;
		end else begin
			if (ctl.cmp_en)
				ge_q <= ge_in;
			if (ctl.load)
				valid_q <= nxt.valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			id_q   <= nxt.id;
			zone_q <= nxt.zone;
		end
	end

endmodule

>>> hdl/zoned_window_stack.sv
// zoned_window_stack: ordered window stacking list with an on-top zone
// top level; uses zws_pkg, zws_cell and zws_prefix_or
// For each command, every cell compares its identifier with the command at the
// edge that accepts the beat, and the row of cells shifts by one place toward
// the front or the back when the command commits, which also loads the result
// register. The row holds STACK_DEPTH cells; the insertion point is
// found by a prefix OR across the row. A new beat is taken once the previous
// command has shifted the row; if the previous result has not been taken, the
// shift waits for it. The list is empty after reset.
module zoned_window_stack #(
	parameter int STACK_DEPTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   op,
	input  logic [zws_pkg::ID_W-1:0]     window_id,
	input  logic                         on_top,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [1:0]                   status,
	output logic [zws_pkg::OUT_W-1:0]    position,
	output logic [zws_pkg::OUT_W-1:0]    entry_count
);

	localparam int N  = STACK_DEPTH;
	localparam int IW = $clog2(N);
	localparam int CW = $clog2(N + 1);
	localparam int XW = (CW > zws_pkg::OUT_W) ? CW : zws_pkg::OUT_W;
	localparam logic [CW-1:0] DEPTH_C = CW'(N);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_UPD  = 1'b1;

	logic                      state_q;
	logic [1:0]                op_q;
	logic [zws_pkg::ID_W-1:0]  id_q;
	logic                      top_q;
	logic                      found_q;
	logic [IW-1:0]             pidx_q;
	logic [CW-1:0]             used_q;
	logic                      out_valid_q;
	logic [1:0]                status_q;
	logic [zws_pkg::OUT_W-1:0] position_q;
	logic [zws_pkg::OUT_W-1:0] count_q;

	zws_pkg::entry_t    ent   [N];
	zws_pkg::entry_t    prime [N];
	zws_pkg::entry_t    new_ent;
	zws_pkg::cell_ctl_t ctl;
	logic [N-1:0] hit;
	logic [N-1:0] ge;
	logic [N-1:0] stop;
	logic [N-1:0] stop_pre;
	logic [N-1:0] lt;
	logic [N-1:0] eq;

	logic          accept;
	logic          commit;
	logic          full;
	logic          refused;
	logic          change;
	logic [1:0]    stop_mode;
	logic          any_hit;
	logic [IW-1:0] hit_idx;
	logic [IW-1:0] w_idx;
	logic [CW-1:0] used_nxt;
	logic [1:0]    status_nxt;
	logic [CW-1:0] pos_nxt;
	logic [XW-1:0] pos_x;
	logic [XW-1:0] cnt_x;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign commit   = (state_q == S_UPD) && (!out_valid_q || out_ready);

	// row of cells
	assign new_ent.id    = id_q;
	assign new_ent.zone  = top_q;
	assign new_ent.valid = 1'b1;

	assign ctl.cmp_en    = accept;
	assign ctl.load      = commit && change;
	assign ctl.stop_mode = stop_mode;

	for (genvar g = 0; g < N; g++) begin : g_cell
		zws_pkg::entry_t right_e;
		zws_pkg::entry_t left_p;
		logic            lt_p;

		if (g == N - 1) begin : g_last
			assign right_e = '0;
		end else begin : g_mid
			assign right_e = ent[g+1];
		end

		if (g == 0) begin : g_first
			assign left_p = '0;
			assign lt_p   = 1'b1;
		end else begin : g_rest
			assign left_p = prime[g-1];
			assign lt_p   = lt[g-1];
		end

		assign eq[g] = lt_p && !lt[g];

		zws_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.cmp_id     (window_id),
			.ge_in      (ge[g]),
			.new_ent    (new_ent),
			.right_ent  (right_e),
			.left_prime (left_p),
			.lt_prev    (lt_p),
			.lt_self    (lt[g]),
			.ent        (ent[g]),
			.prime      (prime[g]),
			.hit        (hit[g]),
			.stop       (stop[g])
		);
	end

	// slots at or after the matched entry
	zws_prefix_or #(.N(N)) u_hit_pre (
		.flags  (hit),
		.prefix (ge)
	);

	// slots before the insertion point
	zws_prefix_or #(.N(N)) u_stop_pre (
		.flags  (stop),
		.prefix (stop_pre)
	);
	assign lt = ~stop_pre;

	// encode matched slot and insertion slot (both one-hot)
	always_comb begin
		any_hit = |hit;
		hit_idx = '0;
		w_idx   = '0;
		for (int i = 0; i < N; i++) begin
			if (hit[i])
				hit_idx = hit_idx | IW'(i);
			if (eq[i])
				w_idx = w_idx | IW'(i);
		end
	end

	// command decode for the shift cycle
	assign full    = (used_q == DEPTH_C);
	assign refused = !found_q && full && (op_q != zws_pkg::OP_REMOVE);

	always_comb begin
		unique case (op_q)
			zws_pkg::OP_FIND: begin
				stop_mode = zws_pkg::STOP_ZONE;
				change    = !found_q && !full;
			end
			zws_pkg::OP_REMOVE: begin
				stop_mode = zws_pkg::STOP_NONE;
				change    = found_q;
			end
			zws_pkg::OP_RAISE: begin
				stop_mode = top_q ? zws_pkg::STOP_ALL : zws_pkg::STOP_ZONE;
				change    = !refused;
			end
			zws_pkg::OP_LOWER: begin
				stop_mode = zws_pkg::STOP_END;
				change    = !refused;
			end
			default: begin
				stop_mode = zws_pkg::STOP_NONE;
				change    = 1'b0;
			end
		endcase
	end

	// result of the command
	always_comb begin
		used_nxt   = used_q;
		status_nxt = zws_pkg::ST_DONE;
		pos_nxt    = DEPTH_C;
		unique case (op_q)
			zws_pkg::OP_FIND: begin
				if (found_q) begin
					status_nxt = zws_pkg::ST_PRESENT;
					pos_nxt    = CW'(pidx_q);
				end else if (full) begin
					status_nxt = zws_pkg::ST_FULL;
				end else begin
					pos_nxt  = CW'(w_idx);
					used_nxt = used_q + CW'(1);
				end
			end
			zws_pkg::OP_REMOVE: begin
				if (found_q)
					used_nxt = used_q - CW'(1);
				else
					status_nxt = zws_pkg::ST_ABSENT;
			end
			default: begin
				if (refused) begin
					status_nxt = zws_pkg::ST_FULL;
				end else begin
					pos_nxt = CW'(w_idx);
					if (!found_q)
						used_nxt = used_q + CW'(1);
				end
			end
		endcase
	end

	assign pos_x = XW'(pos_nxt);
	assign cnt_x = XW'(used_nxt);

	// sequencer, command capture and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (accept) state_q <= S_UPD;
				S_UPD:  if (commit) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
			if (commit)
				used_q <= used_nxt;
			if (commit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// command payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= op;
			id_q    <= window_id;
			top_q   <= on_top;
			found_q <= any_hit;
			pidx_q  <= hit_idx;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (commit) begin
			status_q   <= status_nxt;
			position_q <= pos_x[zws_pkg::OUT_W-1:0];
			count_q    <= cnt_x[zws_pkg::OUT_W-1:0];
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign position    = position_q;
	assign entry_count = count_q;

endmodule

>>> test/tb_zoned_window_stack.sv
`timescale 1ns / 1ps
// tb_zoned_window_stack: self-checking bench for the zoned window stacking list
// holds a list predictor with a scoreboard class, stimulus tasks and the top module
// depends on zws_pkg and zoned_window_stack

localparam int LIST_DEPTH = 16;

typedef struct {
	logic [1:0]               status;
	logic [zws_pkg::OUT_W-1:0] position;
	logic [zws_pkg::OUT_W-1:0] count;
} stack_result_t;

// shadow copy of the stacking list and the queue of predicted results
class stack_scoreboard;
	logic [zws_pkg::ID_W-1:0] ids[LIST_DEPTH];
	logic                     zones[LIST_DEPTH];
	int                       used;
	stack_result_t            expected_q[$];
	int                       errors;

	function new();
		foreach (ids[i]) begin
			ids[i] = '0;
			zones[i] = 1'b0;
		end
		used = 0;
		errors = 0;
	endfunction

	// first back-zone entry, or the end of the list
	function int zone_edge();
		for (int i = 0; i < used; i++) begin
			if (!zones[i])
				return i;
		end
		return used;
	endfunction

	function void take_out(int at);
		for (int i = at; i + 1 < used; i++) begin
			ids[i] = ids[i + 1];
			zones[i] = zones[i + 1];
		end
		used--;
		ids[used] = '0;
		zones[used] = 1'b0;
	endfunction

	function void put_in(int at, logic [zws_pkg::ID_W-1:0] w, logic z);
		if (used >= LIST_DEPTH || at > used)
			return;
		for (int i = used; i > at; i--) begin
			ids[i] = ids[i - 1];
			zones[i] = zones[i - 1];
		end
		ids[at] = w;
		zones[at] = z;
		used++;
	endfunction

	// apply one accepted command beat to the shadow list
	function void note_command(logic [1:0] c, logic [zws_pkg::ID_W-1:0] w, logic t);
		int            hit;
		bit            found;
		int            where;
		stack_result_t r;
		hit = used;
		for (int i = 0; i < used; i++) begin
			if (ids[i] == w) begin
				hit = i;
				break;
			end
		end
		found = hit < used;
		r.status = zws_pkg::ST_DONE;
		where = LIST_DEPTH;
		case (c)
			zws_pkg::OP_FIND: begin
				if (found) begin
					r.status = zws_pkg::ST_PRESENT;
					where = hit;
				end else if (used >= LIST_DEPTH) begin
					r.status = zws_pkg::ST_FULL;
				end else begin
					where = zone_edge();
					put_in(where, w, t);
				end
			end
			zws_pkg::OP_REMOVE: begin
				if (found)
					take_out(hit);
				else
					r.status = zws_pkg::ST_ABSENT;
			end
			default: begin
				if (found)
					take_out(hit);
				if (!found && used >= LIST_DEPTH) begin
					r.status = zws_pkg::ST_FULL;
				end else begin
					if (c == zws_pkg::OP_LOWER)
						where = used;
					else if (t)
						where = 0;
					else
						where = zone_edge();
					put_in(where, w, t);
				end
			end
		endcase
		r.position = where[zws_pkg::OUT_W-1:0];
		r.count = used[zws_pkg::OUT_W-1:0];
		expected_q.push_back(r);
	endfunction

	// compare one result beat with the oldest prediction
	function void check_result(logic [1:0] s, logic [zws_pkg::OUT_W-1:0] p,
		logic [zws_pkg::OUT_W-1:0] n);
		stack_result_t e;
		if (expected_q.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("unexpected result beat: status=%0d position=%0d count=%0d",
					s, p, n);
			return;
		end
		e = expected_q.pop_front();
		if (s !== e.status || p !== e.position || n !== e.count) begin
			errors++;
			if (errors <= 10)
				$display({"mismatch: expected status=%0d position=%0d count=%0d,",
					" got status=%0d position=%0d count=%0d"},
					e.status, e.position, e.count, s, p, n);
		end
	endfunction

	function int pending();
		return expected_q.size();
	endfunction
endclass

module tb_zoned_window_stack;

	localparam int HOLD_CYCLES = 80;
	localparam int RANDOM_ITEMS = 600;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic [1:0]                op = zws_pkg::OP_FIND;
	logic [zws_pkg::ID_W-1:0]  window_id = '0;
	logic                      on_top = 1'b0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic [1:0]                status;
	logic [zws_pkg::OUT_W-1:0] position;
	logic [zws_pkg::OUT_W-1:0] entry_count;

	stack_scoreboard          sb;
	bit                       no_idle = 1'b0;
	bit                       hold_req = 1'b0;
	logic [zws_pkg::ID_W-1:0] id_pool[20];

	zoned_window_stack #(
		.STACK_DEPTH(LIST_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.window_id(window_id),
		.on_top(on_top),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.position(position),
		.entry_count(entry_count)
	);

	always #5 clk = ~clk;

	// mostly short gaps, a few long ones, none in busy stretches
	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 50);
	endfunction

	// offer one command beat and wait until it is taken
	task automatic send_cmd(input logic [1:0] c, input logic [zws_pkg::ID_W-1:0] w,
		input logic t);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= c;
		window_id <= w;
		on_top <= t;
		do @(posedge clk); while (!in_ready);
	endtask

	// beats seen at each edge go to the scoreboard
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_result(status, position, entry_count);
			if (in_valid && in_ready)
				sb.note_command(op, window_id, on_top);
		end
	end

	// result side: random ready, one long hold-off on request
	initial begin
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (no_idle) begin
				out_ready <= 1'b1;
				@(posedge clk);
			end else begin
				out_ready <= ($urandom_range(0, 99) < 65);
				repeat (1 + pick_gap()) @(posedge clk);
			end
		end
	end

	// command side
	initial begin
		int                       rm_pct;
		int                       r;
		logic [1:0]               c;
		logic [zws_pkg::ID_W-1:0] w;
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: identifier extremes, every command, zone corner cases
		send_cmd(zws_pkg::OP_FIND, 16'h0000, 1'b0);
		send_cmd(zws_pkg::OP_FIND, 16'hFFFF, 1'b1);
		send_cmd(zws_pkg::OP_FIND, 16'h0000, 1'b1);
		send_cmd(zws_pkg::OP_REMOVE, 16'h1234, 1'b0);
		send_cmd(zws_pkg::OP_RAISE, 16'h00FF, 1'b0);
		send_cmd(zws_pkg::OP_LOWER, 16'hFFFF, 1'b1);
		send_cmd(zws_pkg::OP_FIND, 16'h0100, 1'b1);
		send_cmd(zws_pkg::OP_RAISE, 16'h0100, 1'b0);
		send_cmd(zws_pkg::OP_REMOVE, 16'h0000, 1'b0);
		// fill the list to the top
		for (int k = 0; k < 13; k++)
			send_cmd(zws_pkg::OP_FIND, 16'(16'h8000 + k), k[0]);
		// inserts refused on a full list, moves still allowed
		send_cmd(zws_pkg::OP_FIND, 16'h4000, 1'b1);
		send_cmd(zws_pkg::OP_RAISE, 16'h4001, 1'b0);
		send_cmd(zws_pkg::OP_LOWER, 16'h4002, 1'b1);
		send_cmd(zws_pkg::OP_RAISE, 16'h8004, 1'b1);
		send_cmd(zws_pkg::OP_LOWER, 16'h00FF, 1'b0);

		// random: identifiers mostly from a small set so that commands hit
		id_pool[0] = 16'h0000;
		id_pool[1] = 16'hFFFF;
		for (int k = 2; k < 20; k++)
			id_pool[k] = 16'($urandom_range(1, 65534));
		rm_pct = 20;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			// change the mix every fifty beats: fill up, churn, drain
			if (i % 50 == 0) begin
				case ($urandom_range(0, 3))
					0: rm_pct = 5;
					1: rm_pct = 20;
					2: rm_pct = 40;
					default: rm_pct = 70;
				endcase
				no_idle = ($urandom_range(0, 3) == 0);
			end
			if (i == 300) begin
				hold_req = 1'b1;
				no_idle = 1'b1;
			end
			r = $urandom_range(0, 99);
			if (r < rm_pct) begin
				c = zws_pkg::OP_REMOVE;
			end else begin
				case ($urandom_range(0, 2))
					0: c = zws_pkg::OP_FIND;
					1: c = zws_pkg::OP_RAISE;
					default: c = zws_pkg::OP_LOWER;
				endcase
			end
			if ($urandom_range(0, 99) < 85)
				w = id_pool[$urandom_range(0, 19)];
			else
				w = 16'($urandom_range(0, 65535));
			send_cmd(c, w, 1'($urandom_range(0, 1)));
		end
		in_valid <= 1'b0;

		// drain, then a short tail to catch stray result beats
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("tb_zoned_window_stack: PASS");
		else
			$display("tb_zoned_window_stack: FAIL");
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("tb_zoned_window_stack: FAIL");
		$finish;
	end

endmodule
